[sv/segment_intersection_unit_assert.svh]
// Assertion macros used by the queue of the segment intersection unit.
`ifndef SEGMENT_INTERSECTION_UNIT_ASSERT_SVH
`define SEGMENT_INTERSECTION_UNIT_ASSERT_SVH
// Same-cycle implication, checked out of reset.
`define SIU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked out of reset.
`define SIU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

[sv/siu_pkg.sv]
// Shared constants and types of the segment intersection unit.
package siu_pkg;
  localparam int COORD_BITS_DEF = 32;
  localparam int Q_DEPTH = 8;
  localparam int Q_AW = 3;
  localparam int Q_CW = 4;

  typedef struct packed {
    logic            empty;
    logic [Q_CW-1:0] level;
  } q_stat_t;
endpackage

[sv/siu_front.sv]
// Front end: differences, bounding boxes, exact cross products, crossing test.
module siu_front #(
  parameter int CB = siu_pkg::COORD_BITS_DEF,
  localparam int NW = 2*CB+1,
  localparam int RW = 4 + 4*CB + 2*NW
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [CB-1:0] in_first_start_x,
  input  logic signed [CB-1:0] in_first_start_y,
  input  logic signed [CB-1:0] in_first_end_x,
  input  logic signed [CB-1:0] in_first_end_y,
  input  logic signed [CB-1:0] in_second_start_x,
  input  logic signed [CB-1:0] in_second_start_y,
  input  logic signed [CB-1:0] in_second_end_x,
  input  logic signed [CB-1:0] in_second_end_y,
  input  siu_pkg::q_stat_t     q_stat,
  output logic                 push,
  output logic [RW-1:0]        rec
);
  localparam int DW = CB+1;
  localparam int XW = 2*CB+2;

  typedef struct packed {
    logic                 hit;
    logic                 par;
    logic                 negx;
    logic                 negy;
    logic signed [CB-1:0] p1x;
    logic signed [CB-1:0] p1y;
    logic [CB-1:0]        dxm;
    logic [CB-1:0]        dym;
    logic [NW-1:0]        numm;
    logic [NW-1:0]        denm;
  } rec_t;

  function automatic logic [NW-1:0] mag_x(input logic signed [XW-1:0] v);
    logic [XW-1:0] t;
    t = v[XW-1] ? -v : v;
    return t[NW-1:0];
  endfunction

  function automatic logic [CB-1:0] mag_d(input logic signed [DW-1:0] v);
    logic [DW-1:0] t;
    t = v[DW-1] ? -v : v;
    return t[CB-1:0];
  endfunction

  logic                 acc;
  logic signed [DW-1:0] p1x_e, p1y_e, p2x_e, p2y_e, q1x_e, q1y_e, q2x_e, q2y_e;
  logic signed [CB-1:0] pxlo, pxhi, pylo, pyhi, qxlo, qxhi, qylo, qyhi;
  logic                 box_nxt;

  // stage 1
  logic                 v1_r, box1_r;
  logic signed [CB-1:0] p1x1_r, p1y1_r;
  logic signed [DW-1:0] dpx1_r, dpy1_r, dqx_r, dqy_r, aqx_r, aqy_r;
  logic signed [DW-1:0] bqx_r, bqy_r, eqx_r, eqy_r;
  // stage 2
  logic                 v2_r, box2_r;
  logic signed [CB-1:0] p1x2_r, p1y2_r;
  logic signed [DW-1:0] dpx2_r, dpy2_r;
  logic signed [XW-1:0] c1a_r, c1b_r, c2a_r, c2b_r, c4a_r, c4b_r;
  logic signed [XW-1:0] na_r, nb_r, da_r, db_r;
  // stage 3
  logic                 v3_r, box3_r;
  logic signed [CB-1:0] p1x3_r, p1y3_r;
  logic signed [DW-1:0] dpx3_r, dpy3_r;
  logic signed [XW-1:0] c1_r, c2_r, c4_r, num_r, den_r;

  logic [siu_pkg::Q_CW:0] fill;
  rec_t                   rec_w;
  logic                   z1, z2, z4, zn;

  assign fill = (siu_pkg::Q_CW+1)'(q_stat.level) + (siu_pkg::Q_CW+1)'(v1_r)
              + (siu_pkg::Q_CW+1)'(v2_r) + (siu_pkg::Q_CW+1)'(v3_r);
  assign busy = fill >= (siu_pkg::Q_CW+1)'(siu_pkg::Q_DEPTH);
  assign acc  = start && !busy;

  always_comb begin
    p1x_e = DW'(in_first_start_x);
    p1y_e = DW'(in_first_start_y);
    p2x_e = DW'(in_first_end_x);
    p2y_e = DW'(in_first_end_y);
    q1x_e = DW'(in_second_start_x);
    q1y_e = DW'(in_second_start_y);
    q2x_e = DW'(in_second_end_x);
    q2y_e = DW'(in_second_end_y);
    pxlo = (in_first_start_x < in_first_end_x) ? in_first_start_x : in_first_end_x;
    pxhi = (in_first_start_x < in_first_end_x) ? in_first_end_x : in_first_start_x;
    pylo = (in_first_start_y < in_first_end_y) ? in_first_start_y : in_first_end_y;
    pyhi = (in_first_start_y < in_first_end_y) ? in_first_end_y : in_first_start_y;
    qxlo = (in_second_start_x < in_second_end_x) ? in_second_start_x : in_second_end_x;
    qxhi = (in_second_start_x < in_second_end_x) ? in_second_end_x : in_second_start_x;
    qylo = (in_second_start_y < in_second_end_y) ? in_second_start_y : in_second_end_y;
    qyhi = (in_second_start_y < in_second_end_y) ? in_second_end_y : in_second_start_y;
    box_nxt = (pxlo <= qxhi) && (pylo <= qyhi) && (qxlo <= pxhi) && (qylo <= pyhi);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= acc;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    box1_r <= box_nxt;
    p1x1_r <= in_first_start_x;
    p1y1_r <= in_first_start_y;
    dpx1_r <= p2x_e - p1x_e;
    dpy1_r <= p2y_e - p1y_e;
    dqx_r  <= q2x_e - q1x_e;
    dqy_r  <= q2y_e - q1y_e;
    aqx_r  <= q1x_e - p1x_e;
    aqy_r  <= q1y_e - p1y_e;
    bqx_r  <= q2x_e - p1x_e;
    bqy_r  <= q2y_e - p1y_e;
    eqx_r  <= p2x_e - q1x_e;
    eqy_r  <= p2y_e - q1y_e;

    box2_r <= box1_r;
    p1x2_r <= p1x1_r;
    p1y2_r <= p1y1_r;
    dpx2_r <= dpx1_r;
    dpy2_r <= dpy1_r;
    c1a_r  <= XW'(aqx_r) * XW'(dpy1_r);
    c1b_r  <= XW'(aqy_r) * XW'(dpx1_r);
    c2a_r  <= XW'(bqx_r) * XW'(dpy1_r);
    c2b_r  <= XW'(bqy_r) * XW'(dpx1_r);
    c4a_r  <= XW'(eqx_r) * XW'(dqy_r);
    c4b_r  <= XW'(eqy_r) * XW'(dqx_r);
    na_r   <= XW'(aqx_r) * XW'(dqy_r);
    nb_r   <= XW'(aqy_r) * XW'(dqx_r);
    da_r   <= XW'(dpx1_r) * XW'(dqy_r);
    db_r   <= XW'(dpy1_r) * XW'(dqx_r);

    box3_r <= box2_r;
    p1x3_r <= p1x2_r;
    p1y3_r <= p1y2_r;
    dpx3_r <= dpx2_r;
    dpy3_r <= dpy2_r;
    c1_r   <= c1a_r - c1b_r;
    c2_r   <= c2a_r - c2b_r;
    c4_r   <= c4a_r - c4b_r;
    num_r  <= na_r - nb_r;
    den_r  <= da_r - db_r;
  end

  // The P1 side straddle sign is the negated numerator.
  always_comb begin
    z1 = (c1_r == '0);
    z2 = (c2_r == '0);
    z4 = (c4_r == '0);
    zn = (num_r == '0);
    rec_w.hit  = box3_r && (z1 || z2 || (c1_r[XW-1] != c2_r[XW-1]))
                        && (zn || z4 || (num_r[XW-1] == c4_r[XW-1]));
    rec_w.par  = (den_r == '0);
    rec_w.negx = dpx3_r[DW-1] ^ num_r[XW-1] ^ den_r[XW-1];
    rec_w.negy = dpy3_r[DW-1] ^ num_r[XW-1] ^ den_r[XW-1];
    rec_w.p1x  = p1x3_r;
    rec_w.p1y  = p1y3_r;
    rec_w.dxm  = mag_d(dpx3_r);
    rec_w.dym  = mag_d(dpy3_r);
    rec_w.numm = mag_x(num_r);
    rec_w.denm = mag_x(den_r);
  end

  assign push = v3_r;
  assign rec  = rec_w;
endmodule

[sv/siu_queue.sv]
// Short word queue between front and back ends.
`include "segment_intersection_unit_assert.svh"
module siu_queue #(
  parameter int W = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [W-1:0]     din,
  input  logic             pop,
  output logic [W-1:0]     dout,
  output siu_pkg::q_stat_t stat
);
  logic [W-1:0]                mem_r [siu_pkg::Q_DEPTH];
  logic [siu_pkg::Q_AW-1:0]    wp_r, rp_r;
  logic [siu_pkg::Q_CW-1:0]    count_r, count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= din;
    end
  end

  assign dout       = mem_r[rp_r];
  assign stat.empty = (count_r == '0);
  assign stat.level = count_r;

  `SIU_ASSERT_IMP(a_no_overflow, push && !pop,
    count_r < siu_pkg::Q_CW'(siu_pkg::Q_DEPTH), "queue overflow")
  `SIU_ASSERT_IMP(a_pop_nonempty, pop, count_r != '0, "pop from empty queue")
  `SIU_ASSERT_NXT(a_level_up, push && !pop, count_r == $past(count_r) + 1'b1,
    "queue level lost a push")
endmodule

[sv/siu_back.sv]
// Back end: offset product, pipelined restoring division, rounding, saturation.
module siu_back #(
  parameter int CB = siu_pkg::COORD_BITS_DEF,
  localparam int NW = 2*CB+1,
  localparam int RW = 4 + 4*CB + 2*NW
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  siu_pkg::q_stat_t     q_stat,
  input  logic [RW-1:0]        rec,
  output logic                 pop,
  output logic                 out_valid,
  output logic                 out_segments_cross,
  output logic                 out_lines_parallel,
  output logic signed [CB-1:0] out_point_x,
  output logic signed [CB-1:0] out_point_y,
  output logic                 out_point_clipped
);
  localparam int LW = (NW+1)/2;
  localparam int HW = NW - LW;
  localparam int PW = CB + NW;
  localparam int EW = NW + CB + 1;
  localparam int QW = CB + 1;
  localparam int SW = CB + 4;
  localparam logic signed [SW-1:0] MAXV = SW'((64'sd1 <<< (CB-1)) - 64'sd1);
  localparam logic signed [SW-1:0] MINV = -MAXV - SW'(1);

  typedef struct packed {
    logic                 hit;
    logic                 par;
    logic                 negx;
    logic                 negy;
    logic signed [CB-1:0] p1x;
    logic signed [CB-1:0] p1y;
    logic [CB-1:0]        dxm;
    logic [CB-1:0]        dym;
    logic [NW-1:0]        numm;
    logic [NW-1:0]        denm;
  } rec_t;

  typedef struct packed {
    logic                 hit;
    logic                 par;
    logic                 negx;
    logic                 negy;
    logic                 ovfx;
    logic                 ovfy;
    logic signed [CB-1:0] p1x;
    logic signed [CB-1:0] p1y;
    logic [NW-1:0]        denm;
    logic [EW-1:0]        rx;
    logic [EW-1:0]        ry;
    logic [QW-1:0]        qx;
    logic [QW-1:0]        qy;
  } dv_t;

  typedef struct packed {
    logic                 hit;
    logic                 par;
    logic                 negx;
    logic                 negy;
    logic                 ovfx;
    logic                 ovfy;
    logic signed [CB-1:0] p1x;
    logic signed [CB-1:0] p1y;
    logic [QW:0]          qrx;
    logic [QW:0]          qry;
  } rd_t;

  // Returns {clip, value}.
  function automatic logic [CB:0] place(input logic signed [CB-1:0] base,
                                        input logic [QW:0] qr,
                                        input logic neg, input logic ovf);
    logic signed [SW-1:0] qe, sv;
    logic [CB:0]          res;
    qe = $signed(SW'(qr));
    sv = SW'(base) + (neg ? -qe : qe);
    if (ovf) begin
      res = neg ? {1'b1, MINV[CB-1:0]} : {1'b1, MAXV[CB-1:0]};
    end else if (sv > MAXV) begin
      res = {1'b1, MAXV[CB-1:0]};
    end else if (sv < MINV) begin
      res = {1'b1, MINV[CB-1:0]};
    end else begin
      res = {1'b0, sv[CB-1:0]};
    end
    return res;
  endfunction

  rec_t              rin;
  rec_t              rec1_r, rec2_r;
  logic              v1_r, v2_r;
  logic [CB+LW-1:0]  mxl_r, myl_r;
  logic [CB+HW-1:0]  mxh_r, myh_r;
  logic [PW-1:0]     px_r, py_r;
  dv_t               dv_r [0:CB+1];
  logic [CB+1:0]     dvv_r;
  rd_t               rd_r;
  logic              rdv_r;
  dv_t               dl;
  logic [CB:0]       resx, resy;

  assign rin = rec;
  assign pop = !q_stat.empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      dvv_r     <= '0;
      rdv_r     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1_r      <= pop;
      v2_r      <= v1_r;
      dvv_r     <= {dvv_r[CB:0], v2_r};
      rdv_r     <= dvv_r[CB+1];
      out_valid <= rdv_r;
    end
  end

  // Split the numerator so each multiplier stays near 32 bits.
  always_ff @(posedge clk) begin
    rec1_r <= rin;
    mxl_r  <= (CB+LW)'(rin.dxm) * (CB+LW)'(rin.numm[LW-1:0]);
    mxh_r  <= (CB+HW)'(rin.dxm) * (CB+HW)'(rin.numm[NW-1:LW]);
    myl_r  <= (CB+LW)'(rin.dym) * (CB+LW)'(rin.numm[LW-1:0]);
    myh_r  <= (CB+HW)'(rin.dym) * (CB+HW)'(rin.numm[NW-1:LW]);
    rec2_r <= rec1_r;
    px_r   <= PW'(mxl_r) + (PW'(mxh_r) << LW);
    py_r   <= PW'(myl_r) + (PW'(myh_r) << LW);
  end

  // Quotients at or above 2^(CB+1) always saturate.
  always_ff @(posedge clk) begin
    dv_r[0].hit  <= rec2_r.hit;
    dv_r[0].par  <= rec2_r.par;
    dv_r[0].negx <= rec2_r.negx;
    dv_r[0].negy <= rec2_r.negy;
    dv_r[0].ovfx <= EW'(px_r) >= (EW'(rec2_r.denm) << (CB+1));
    dv_r[0].ovfy <= EW'(py_r) >= (EW'(rec2_r.denm) << (CB+1));
    dv_r[0].p1x  <= rec2_r.p1x;
    dv_r[0].p1y  <= rec2_r.p1y;
    dv_r[0].denm <= rec2_r.denm;
    dv_r[0].rx   <= EW'(px_r);
    dv_r[0].ry   <= EW'(py_r);
    dv_r[0].qx   <= '0;
    dv_r[0].qy   <= '0;
  end

  for (genvar k = 0; k <= CB; k++) begin : g_div
    localparam int SH = CB - k;
    logic [EW-1:0] shd;
    logic          gex, gey;
    dv_t           nx;
    always_comb begin
      shd   = EW'(dv_r[k].denm) << SH;
      gex   = dv_r[k].rx >= shd;
      gey   = dv_r[k].ry >= shd;
      nx    = dv_r[k];
      nx.rx = gex ? dv_r[k].rx - shd : dv_r[k].rx;
      nx.ry = gey ? dv_r[k].ry - shd : dv_r[k].ry;
      nx.qx = dv_r[k].qx | (QW'(gex) << SH);
      nx.qy = dv_r[k].qy | (QW'(gey) << SH);
    end
    always_ff @(posedge clk) begin
      dv_r[k+1] <= nx;
    end
  end

  // Round half away from zero on the magnitude.
  assign dl = dv_r[CB+1];
  always_ff @(posedge clk) begin
    rd_r.hit  <= dl.hit;
    rd_r.par  <= dl.par;
    rd_r.negx <= dl.negx;
    rd_r.negy <= dl.negy;
    rd_r.ovfx <= dl.ovfx;
    rd_r.ovfy <= dl.ovfy;
    rd_r.p1x  <= dl.p1x;
    rd_r.p1y  <= dl.p1y;
    rd_r.qrx  <= (QW+1)'(dl.qx) + (QW+1)'((dl.rx << 1) >= EW'(dl.denm));
    rd_r.qry  <= (QW+1)'(dl.qy) + (QW+1)'((dl.ry << 1) >= EW'(dl.denm));
  end

  assign resx = place(rd_r.p1x, rd_r.qrx, rd_r.negx, rd_r.ovfx);
  assign resy = place(rd_r.p1y, rd_r.qry, rd_r.negy, rd_r.ovfy);

  always_ff @(posedge clk) begin
    out_segments_cross <= rd_r.hit;
    out_lines_parallel <= rd_r.par;
    out_point_x        <= rd_r.par ? rd_r.p1x : $signed(resx[CB-1:0]);
    out_point_y        <= rd_r.par ? rd_r.p1y : $signed(resy[CB-1:0]);
    out_point_clipped  <= !rd_r.par && (resx[CB] || resy[CB]);
  end
endmodule

[sv/segment_intersection_unit.sv]
// Throughput: one segment pair per cycle; the divider is one pipelined stage per
// quotient bit, so a new word enters every cycle and busy stays low in steady flow.
// Results cannot be held off; out_valid marks each for exactly one cycle.
// Reset (rst_n low, synchronous) empties the pipeline and the queue; nothing else.
module segment_intersection_unit #(
  parameter int COORD_BITS = siu_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] in_first_start_x,
  input  logic signed [COORD_BITS-1:0] in_first_start_y,
  input  logic signed [COORD_BITS-1:0] in_first_end_x,
  input  logic signed [COORD_BITS-1:0] in_first_end_y,
  input  logic signed [COORD_BITS-1:0] in_second_start_x,
  input  logic signed [COORD_BITS-1:0] in_second_start_y,
  input  logic signed [COORD_BITS-1:0] in_second_end_x,
  input  logic signed [COORD_BITS-1:0] in_second_end_y,
  output logic                         out_valid,
  output logic                         out_segments_cross,
  output logic                         out_lines_parallel,
  output logic signed [COORD_BITS-1:0] out_point_x,
  output logic signed [COORD_BITS-1:0] out_point_y,
  output logic                         out_point_clipped
);
  localparam int NW = 2*COORD_BITS+1;
  localparam int RW = 4 + 4*COORD_BITS + 2*NW;

  logic             push, pop;
  logic [RW-1:0]    q_in, q_out;
  siu_pkg::q_stat_t q_stat;

  siu_front #(.CB(COORD_BITS)) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_first_start_x  (in_first_start_x),
    .in_first_start_y  (in_first_start_y),
    .in_first_end_x    (in_first_end_x),
    .in_first_end_y    (in_first_end_y),
    .in_second_start_x (in_second_start_x),
    .in_second_start_y (in_second_start_y),
    .in_second_end_x   (in_second_end_x),
    .in_second_end_y   (in_second_end_y),
    .q_stat            (q_stat),
    .push              (push),
    .rec               (q_in)
  );

  siu_queue #(.W(RW)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (q_in),
    .pop   (pop),
    .dout  (q_out),
    .stat  (q_stat)
  );

  siu_back #(.CB(COORD_BITS)) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_stat             (q_stat),
    .rec                (q_out),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_segments_cross (out_segments_cross),
    .out_lines_parallel (out_lines_parallel),
    .out_point_x        (out_point_x),
    .out_point_y        (out_point_y),
    .out_point_clipped  (out_point_clipped)
  );
endmodule

[test/segment_intersection_unit_tb.sv]
// Self-checking testbench for the segment intersection unit: directed and random segment pairs.
`timescale 1ns / 1ps

module segment_intersection_unit_tb;
  localparam int CB = siu_pkg::COORD_BITS_DEF;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_ITEMS = 1100;

  typedef logic signed [CB-1:0] coord_t;
  typedef logic signed [159:0] wide_t;
  typedef struct {
    coord_t v[8];
  } seg_pair_t;
  typedef struct packed {
    bit     hit;
    bit     parallel;
    coord_t px;
    coord_t py;
    bit     clipped;
  } isect_t;

  class isect_scoreboard;
    isect_t pending[$];
    int     mismatches;
    int     orphans;

    function new();
      mismatches = 0;
      orphans = 0;
    endfunction

    static function wide_t cross2(longint ux, longint uy, longint vx, longint vy);
      return wide_t'(ux) * wide_t'(vy) - wide_t'(uy) * wide_t'(vx);
    endfunction

    static function int sgn(wide_t a);
      return (a == 0) ? 0 : ((a < 0) ? -1 : 1);
    endfunction

    // base + delta*num/den rounded half away from zero, then clamped
    static function coord_t place(longint base, longint delta, wide_t num, wide_t den,
                                  inout bit clip);
      wide_t prod, mp, md, q, r, sum, hi, lo;
      prod = wide_t'(delta) * num;
      mp = (prod < 0) ? -prod : prod;
      md = (den < 0) ? -den : den;
      q = mp / md;
      r = mp % md;
      hi = wide_t'(64'sd2147483647);
      lo = -wide_t'(64'sd2147483648);
      if (2 * r >= md) q = q + 1;
      if ((prod < 0) != (den < 0)) q = -q;
      sum = wide_t'(base) + q;
      if (sum > hi) begin
        clip = 1;
        return coord_t'(hi);
      end
      if (sum < lo) begin
        clip = 1;
        return coord_t'(lo);
      end
      return coord_t'(sum);
    endfunction

    function void note(seg_pair_t s);
      longint p1x, p1y, p2x, p2y, q1x, q1y, q2x, q2y, dpx, dpy, dqx, dqy;
      wide_t den, num;
      isect_t e;
      bit boxes, clip;
      p1x = s.v[0]; p1y = s.v[1]; p2x = s.v[2]; p2y = s.v[3];
      q1x = s.v[4]; q1y = s.v[5]; q2x = s.v[6]; q2y = s.v[7];
      dpx = p2x - p1x; dpy = p2y - p1y; dqx = q2x - q1x; dqy = q2y - q1y;
      boxes = ((p1x < p2x ? p1x : p2x) <= (q1x > q2x ? q1x : q2x))
           && ((p1y < p2y ? p1y : p2y) <= (q1y > q2y ? q1y : q2y))
           && ((q1x < q2x ? q1x : q2x) <= (p1x > p2x ? p1x : p2x))
           && ((q1y < q2y ? q1y : q2y) <= (p1y > p2y ? p1y : p2y));
      e.hit = 0;
      if (boxes)
        e.hit = (sgn(cross2(q1x - p1x, q1y - p1y, dpx, dpy))
                 * sgn(cross2(q2x - p1x, q2y - p1y, dpx, dpy)) <= 0)
             && (sgn(cross2(p1x - q1x, p1y - q1y, dqx, dqy))
                 * sgn(cross2(p2x - q1x, p2y - q1y, dqx, dqy)) <= 0);
      den = cross2(dpx, dpy, dqx, dqy);
      clip = 0;
      e.parallel = (den == 0);
      if (e.parallel) begin
        e.px = s.v[0];
        e.py = s.v[1];
      end else begin
        num = cross2(q1x - p1x, q1y - p1y, dqx, dqy);
        e.px = place(p1x, dpx, num, den, clip);
        e.py = place(p1y, dpy, num, den, clip);
      end
      e.clipped = clip;
      pending.push_back(e);
    endfunction

    function void check(isect_t a);
      isect_t e;
      if (pending.size() == 0) begin
        orphans++;
        if (orphans + mismatches <= 10)
          $display("ERROR: unexpected result word cross=%0b par=%0b x=%0d y=%0d clip=%0b",
                   a.hit, a.parallel, a.px, a.py, a.clipped);
        return;
      end
      e = pending.pop_front();
      if (e != a) begin
        mismatches++;
        if (orphans + mismatches <= 10)
          $display({"ERROR: mismatch exp cross=%0b par=%0b x=%0d y=%0d clip=%0b",
                    " got cross=%0b par=%0b x=%0d y=%0d clip=%0b"},
                   e.hit, e.parallel, e.px, e.py, e.clipped,
                   a.hit, a.parallel, a.px, a.py, a.clipped);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  seg_pair_t drv;
  logic out_valid, out_segments_cross, out_lines_parallel, out_point_clipped;
  coord_t out_point_x, out_point_y;

  isect_scoreboard sb;
  int accepted;
  int idle_cycles;

  segment_intersection_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_first_start_x(drv.v[0]), .in_first_start_y(drv.v[1]),
    .in_first_end_x(drv.v[2]), .in_first_end_y(drv.v[3]),
    .in_second_start_x(drv.v[4]), .in_second_start_y(drv.v[5]),
    .in_second_end_x(drv.v[6]), .in_second_end_y(drv.v[7]),
    .out_valid(out_valid), .out_segments_cross(out_segments_cross),
    .out_lines_parallel(out_lines_parallel), .out_point_x(out_point_x),
    .out_point_y(out_point_y), .out_point_clipped(out_point_clipped)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Track accepted words and results; the watchdog counts cycles with neither.
  always @(posedge clk) begin
    isect_t a;
    if (rst_n) begin
      if (start && !busy) begin
        sb.note(drv);
        accepted++;
      end
      if (out_valid) begin
        a.hit = out_segments_cross;
        a.parallel = out_lines_parallel;
        a.px = out_point_x;
        a.py = out_point_y;
        a.clipped = out_point_clipped;
        sb.check(a);
      end
      if ((start && !busy) || out_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic send(seg_pair_t s);
    int n;
    drv <= s;
    start <= 1'b1;
    n = accepted;
    do @(negedge clk); while (accepted == n);
  endtask

  task automatic hold_idle(int n);
    start <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (sb.pending.size() != 0);
  endtask

  function automatic seg_pair_t mk(int a, int b, int c, int d, int e, int f, int g, int h);
    seg_pair_t s;
    s.v[0] = a; s.v[1] = b; s.v[2] = c; s.v[3] = d;
    s.v[4] = e; s.v[5] = f; s.v[6] = g; s.v[7] = h;
    return s;
  endfunction

  function automatic coord_t rand_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'(($urandom_range(0, 200) - 100) <<< 16);
      2: return coord_t'($urandom_range(0, 64) - 32);
      default: return ($urandom_range(0, 1)) ? coord_t'(32'h7fffffff) : coord_t'(32'h80000000);
    endcase
  endfunction

  function automatic seg_pair_t rand_pair();
    seg_pair_t s;
    int mode, kind;
    mode = $urandom_range(0, 9);
    mode = (mode < 3) ? 0 : (mode < 7) ? 1 : (mode < 9) ? 2 : 3;
    for (int i = 0; i < 8; i++) begin
      s.v[i] = ($urandom_range(0, 15) == 0) ? rand_coord($urandom_range(0, 3))
                                             : rand_coord(mode);
    end
    kind = $urandom_range(0, 7);
    // make the second segment parallel, or collinear, or share an endpoint
    if (kind == 0) begin
      s.v[6] = s.v[4] + (s.v[2] - s.v[0]);
      s.v[7] = s.v[5] + (s.v[3] - s.v[1]);
    end else if (kind == 1) begin
      s.v[4] = s.v[2];
      s.v[5] = s.v[3];
    end else if (kind == 2 && mode != 0) begin
      s.v[4] = s.v[0] + 2 * (s.v[2] - s.v[0]);
      s.v[5] = s.v[1] + 2 * (s.v[3] - s.v[1]);
      s.v[6] = s.v[0] - (s.v[2] - s.v[0]);
      s.v[7] = s.v[1] - (s.v[3] - s.v[1]);
    end
    return s;
  endfunction

  localparam int MX = 32'h7fffffff;
  localparam int MN = 32'h80000000;
  localparam int U = 32'h00010000;

  initial begin
    seg_pair_t dir[$];
    sb = new();
    accepted = 0;
    idle_cycles = 0;
    rst_n = 0;
    start = 0;
    drv = mk(0, 0, 0, 0, 0, 0, 0, 0);
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    dir.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0));
    dir.push_back(mk(MN, MN, MX, MX, MN, MX, MX, MN));
    dir.push_back(mk(MX, MX, MN, MN, MX, MN, MN, MX));
    dir.push_back(mk(0, 0, 2*U, 2*U, 0, 2*U, 2*U, 0));
    dir.push_back(mk(0, 0, 4*U, 0, 0, U, 4*U, U));
    dir.push_back(mk(0, 0, 4*U, 0, 2*U, 0, 6*U, 0));
    dir.push_back(mk(0, 0, 4*U, 0, 5*U, 0, 6*U, 0));
    dir.push_back(mk(0, 0, 2*U, 2*U, 2*U, 2*U, 4*U, 0));
    dir.push_back(mk(0, 0, 2*U, 0, U, 0, U, 3*U));
    dir.push_back(mk(0, 0, U, 0, 3*U, -U, 3*U, U));
    dir.push_back(mk(U, U, U, U, U, U, U, U));
    dir.push_back(mk(U, U, U, U, 0, 0, 2*U, 2*U));
    dir.push_back(mk(0, 0, 1, 0, MN, 1, MX, 2));
    dir.push_back(mk(MX, 0, MX - 1, 1, MX, 5, MX - 1, 7));
    dir.push_back(mk(MN, 0, MN + 1, 1, MN, 5, MN + 1, 7));
    dir.push_back(mk(0, 0, 3, 0, 0, 0, 1, 3));
    dir.push_back(mk(0, 0, 3, 1, 0, 1, 3, 0));
    dir.push_back(mk(-1, -1, 1, 2, 2, -3, -2, 1));
    dir.push_back(mk(MX, MN, MN, MX, MN, MN, MX, MX));
    dir.push_back(mk(-1, -1, -1, -1, -1, -1, -1, -1));
    foreach (dir[i]) send(dir[i]);
    drain();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      send(rand_pair());
      if (i == RANDOM_ITEMS / 2) drain();
      else if (i < RANDOM_ITEMS - 200 && $urandom_range(0, 5) == 0)
        hold_idle($urandom_range(1, 16));
    end
    drain();
    repeat (CB + 20) @(negedge clk);
    if (sb.mismatches == 0 && sb.orphans == 0 && sb.pending.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end
endmodule

[files.f]
+incdir+sv
sv/siu_pkg.sv
sv/siu_front.sv
sv/siu_queue.sv
sv/siu_back.sv
sv/segment_intersection_unit.sv
test/segment_intersection_unit_tb.sv
